// ===== hw/rtl/xoro_pkg.sv =====
// Shared types, constants and the generator step function for the xoroshiro128+ block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package xoro_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned InDataW = 72;
  localparam int unsigned JumpLen = 128;
  localparam int unsigned JumpCntW = $clog2(JumpLen);

  localparam logic [ModeW-1:0] MODE_RAW   = 2'd0;
  localparam logic [ModeW-1:0] MODE_BOUND = 2'd1;
  localparam logic [ModeW-1:0] MODE_JUMP  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SEED0 = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_SEED1 = 1'b1;

  localparam logic [WordW-1:0] Seed0Reset = 64'd1;
  localparam logic [WordW-1:0] Seed1Reset = 64'd0;

  // Jump polynomial, lower word in the low half; bit k is used at jump step k.
  localparam logic [JumpLen-1:0] JumpPoly = {64'hd86b048b86aa9922, 64'hbeac0467eba5facb};

  typedef struct packed {
    logic step;      // advance the generator by one step
    logic acc_clr;   // clear the jump accumulator
    logic acc_xor;   // fold the current state into the accumulator
    logic acc_load;  // replace the state by the accumulator
  } state_ctl_t;

  typedef struct packed {
    logic [WordW-1:0] w0;
    logic [WordW-1:0] w1;
  } gen_state_t;

  // One xoroshiro128+ step: rotate 55, shift 14, rotate 36.
  function automatic gen_state_t xoro_advance(input gen_state_t s);
    gen_state_t       n;
    logic [WordW-1:0] b;
    b    = s.w1 ^ s.w0;
    n.w0 = {s.w0[8:0], s.w0[63:9]} ^ b ^ {b[49:0], 14'd0};
    n.w1 = {b[27:0], b[63:28]};
    return n;
  endfunction

endpackage

// ===== hw/rtl/xoroshiro128plus_generator.sv =====
// Top level of the xoroshiro128+ generator: sequencer, output register and channels.
// Depends on xoro_pkg, xoro_state and xoro_divider.
//
//   Channel     Direction  Contents
//   s_axis      in         tdata[1:0] mode, tdata[65:2] bound, tdata[71:66] zero
//   m_axis      out        tdata[63:0] value
//   cfg         in         write enable, register index, 64-bit seed word
//
// A raw draw, a zero bound and the unused mode go from acceptance straight to the finish; a jump
// passes the accepting cycle, one step per jump-polynomial bit, a load and a finish.
// A bounded draw passes acceptance, the range division and the finish, plus, for each draw,
// one step and one pass of the shared divider.
// Reset loads the state from the seed reset values. One item is in work at a time;
// a finished result waits in the output register while the next item is taken, and the
// sequencer holds its result if the output register is still full.
`timescale 1ns / 1ps

module xoroshiro128plus_generator import xoro_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,   // [1:0] mode, [65:2] bound
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [WordW-1:0]   m_axis_tdata,   // [63:0] value
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RANGE,
    ST_DRAW,
    ST_DIV_DRAW,
    ST_JUMP,
    ST_JLOAD,
    ST_FINISH
  } fsm_e;

  fsm_e                state_q;
  logic [WordW-1:0]    bound_q;
  logic [WordW-1:0]    range_q;
  logic [WordW-1:0]    res_q;
  logic [JumpCntW-1:0] jcnt_q;
  logic                m_tvalid_q;
  logic [WordW-1:0]    m_tdata_q;

  logic [ModeW-1:0]    in_mode;
  logic [WordW-1:0]    in_bound;
  logic                accept;
  state_ctl_t          ctl;
  logic [WordW-1:0]    sum;
  logic                div_start;
  logic [WordW-1:0]    div_dividend;
  logic [WordW-1:0]    div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [WordW-1:0]    div_quot;

  assign in_mode  = s_axis_tdata[ModeW-1:0];
  assign in_bound = s_axis_tdata[ModeW+WordW-1:ModeW];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    ctl          = '0;
    div_start    = 1'b0;
    div_dividend = sum;
    div_divisor  = range_q;
    if (accept) begin
      case (in_mode)
        MODE_RAW:   ctl.step = 1'b1;
        MODE_BOUND: begin
          if (in_bound != '0) begin
            div_start    = 1'b1;
            div_dividend = '1;
            div_divisor  = in_bound;
          end
        end
        MODE_JUMP:  ctl.acc_clr = 1'b1;
        default:    ;
      endcase
    end
    case (state_q)
      ST_DRAW: begin
        // The draw divides the sum taken before the step.
        ctl.step  = 1'b1;
        div_start = 1'b1;
      end
      ST_JUMP: begin
        ctl.step    = 1'b1;
        ctl.acc_xor = JumpPoly[jcnt_q];
      end
      ST_JLOAD: ctl.acc_load = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      jcnt_q     <= '0;
      m_tvalid_q <= 1'b0;
      bound_q    <= '0;
      range_q    <= '0;
      res_q      <= '0;
      m_tdata_q  <= '0;
    end else begin
      // In the finish state the output register is handled below.
      if (m_tvalid_q && m_axis_tready && state_q != ST_FINISH) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            bound_q <= in_bound;
            case (in_mode)
              MODE_RAW: begin
                res_q   <= sum;
                state_q <= ST_FINISH;
              end
              MODE_BOUND: begin
                res_q <= '0;
                if (in_bound != '0) begin
                  state_q <= ST_DIV_RANGE;
                end else begin
                  state_q <= ST_FINISH;
                end
              end
              MODE_JUMP: begin
                res_q   <= '0;
                jcnt_q  <= '0;
                state_q <= ST_JUMP;
              end
              default: begin
                res_q   <= '0;
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_DIV_RANGE: begin
          if (div_done) begin
            range_q <= div_quot;
            state_q <= ST_DRAW;
          end
        end
        ST_DRAW: state_q <= ST_DIV_DRAW;
        ST_DIV_DRAW: begin
          if (div_done) begin
            if (div_quot < bound_q) begin
              res_q   <= div_quot;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_DRAW;
            end
          end
        end
        ST_JUMP: begin
          jcnt_q <= jcnt_q + 1'b1;
          if (jcnt_q == JumpCntW'(JumpLen - 1)) begin
            state_q <= ST_JLOAD;
          end
        end
        ST_JLOAD: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= res_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  xoro_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .sum_o      (sum)
  );

  xoro_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // The divider is never restarted while a division is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");

  // A division result only ever arrives while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_RANGE || state_q == ST_DIV_DRAW))
    else $error("divider finished outside a wait state");

  // A new result only appears after the sequencer has finished an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised without a finished item");

  // A bounded result handed over is always below its bound.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_DRAW && div_done && div_quot < bound_q) |=> (res_q < bound_q))
    else $error("bounded result not below its bound");

endmodule

// ===== hw/rtl/xoro_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, for 64-bit unsigned operands.
// Depends on xoro_pkg for the word width.
`timescale 1ns / 1ps

module xoro_divider import xoro_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] dividend_i,
  input  logic [WordW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WordW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(WordW);

  logic [WordW-1:0] rem_q, rem_d;
  logic [WordW-1:0] quo_q, quo_d;
  logic [WordW-1:0] div_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WordW:0]   shifted;
  logic             ge;

  // The quotient register doubles as the dividend shifter: dividend bits leave at the top
  // while quotient bits enter at the bottom.
  always_comb begin
    shifted = {rem_q, quo_q[WordW-1]};
    ge      = (shifted >= {1'b0, div_q});
    rem_d   = ge ? WordW'(shifted - {1'b0, div_q}) : shifted[WordW-1:0];
    quo_d   = {quo_q[WordW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/xoro_state.sv =====
// Generator state words, seed registers and the jump accumulator.
// Depends on xoro_pkg for the step function and the control struct.
`timescale 1ns / 1ps

module xoro_state import xoro_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [WordW-1:0]   cfg_data_i,
  input  state_ctl_t         ctl_i,
  output logic [WordW-1:0]   sum_o
);

  logic [WordW-1:0] seed0_q, seed0_d;
  logic [WordW-1:0] seed1_q, seed1_d;
  gen_state_t       gen_q, gen_d;
  gen_state_t       acc_q;

  always_comb begin
    seed0_d = seed0_q;
    seed1_d = seed1_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEED0: seed0_d = cfg_data_i;
        REG_SEED1: seed1_d = cfg_data_i;
        default:   ;
      endcase
    end
    gen_d = gen_q;
    if (cfg_we_i) begin
      // A write to either seed reloads both state words.
      gen_d.w0 = seed0_d;
      gen_d.w1 = seed1_d;
    end else if (ctl_i.acc_load) begin
      gen_d = acc_q;
    end else if (ctl_i.step) begin
      gen_d = xoro_advance(gen_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed0_q  <= Seed0Reset;
      seed1_q  <= Seed1Reset;
      gen_q.w0 <= Seed0Reset;
      gen_q.w1 <= Seed1Reset;
    end else begin
      seed0_q <= seed0_d;
      seed1_q <= seed1_d;
      gen_q   <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc_xor) begin
      acc_q <= acc_q ^ gen_q;
    end
  end

  assign sum_o = gen_q.w0 + gen_q.w1;

endmodule
